FILE: hw/rtl/sobol_sequence_generator_core_assert.svh
// ---------------------------------------------------------------------------
// sobol sequence generator core assertion macros
// shared property forms, sampled on clock and disabled during reset
// ---------------------------------------------------------------------------
`ifndef SOBOL_SEQUENCE_GENERATOR_CORE_ASSERT_SVH
`define SOBOL_SEQUENCE_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication
`define SOBOL_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SOBOL_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/sobol_pkg.sv
// ---------------------------------------------------------------------------
// sobol_pkg
// shared types, codes and defaults of the sobol sequence generator
// ---------------------------------------------------------------------------
`default_nettype none

package sobol_pkg;

   localparam int BITS_DEFAULT     = 15;
   localparam int MAX_DIMS_DEFAULT = 8;
   localparam int WORD_DEFAULT     = 32;
   localparam int QUEUE_DEPTH      = 2;

   localparam logic [1:0] ACT_LOAD    = 2'd0;
   localparam logic [1:0] ACT_NEXT    = 2'd1;
   localparam logic [1:0] ACT_RESTART = 2'd2;

   localparam logic [1:0] CSR_DIMS_IN_USE   = 2'd0;
   localparam logic [1:0] CSR_POINTS_IN_USE = 2'd1;

   localparam logic [3:0]  DIMS_RESET   = 4'd8;
   localparam logic [15:0] POINTS_RESET = 16'd32768;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_NEXT,
      CMD_RESTART
   } sobol_cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } sobol_state_type;

   typedef struct packed {
      logic running;
      logic stage_vld;
   } sobol_status_type;

endpackage

`default_nettype wire

FILE: hw/rtl/sobol_queue.sv
// ---------------------------------------------------------------------------
// sobol_queue
// short fifo decoupling the command front end from the execution back end
// ---------------------------------------------------------------------------
`default_nettype none

module sobol_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  ready,
   output logic                  valid,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data
);
   import sobol_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign ready    = (count_ff != CW'(QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && ready;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/sobol_front.sv
// ---------------------------------------------------------------------------
// sobol_front
// accepts request transactions, decodes and screens them, holds the csrs
// ---------------------------------------------------------------------------
`default_nettype none

module sobol_front #(
   parameter int BITS     = sobol_pkg::BITS_DEFAULT,
   parameter int MAX_DIMS = sobol_pkg::MAX_DIMS_DEFAULT,
   parameter int WORD     = sobol_pkg::WORD_DEFAULT,
   localparam int AW = (MAX_DIMS * BITS > 1) ? $clog2(MAX_DIMS * BITS) : 1,
   localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [1:0]              req_action,
   input  wire logic [2:0]              req_load_dimension,
   input  wire logic [3:0]              req_load_bit,
   input  wire logic [14:0]             req_direction_value,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [1:0]              csr_index,
   input  wire logic [15:0]             csr_wdata,
   output logic                         q_push,
   input  wire logic                    q_ready,
   output sobol_pkg::sobol_cmd_type     q_cmd,
   output logic [AW-1:0]                q_addr,
   output logic [WORD-1:0]              q_word,
   output logic [DW-1:0]                last_dim,
   output logic [15:0]                  limit
);
   import sobol_pkg::*;

   localparam int unsigned CAP = (BITS < 16) ? (32'd1 << BITS) : 32'd65535;

   logic [3:0]  dims_ff, dims_in;
   logic [15:0] points_ff, points_in;
   logic        load_ok;
   logic        keep;

   assign req_stall = !q_ready;
   assign csr_ready = 1'b1;
   assign q_push    = req_valid && q_ready && keep;

   always_comb begin
      load_ok = (int'(req_load_bit) < BITS) && (int'(req_load_bit) < WORD) &&
                (int'(req_load_dimension) < MAX_DIMS);
      keep  = 1'b0;
      q_cmd = CMD_NEXT;
      case (req_action)
         ACT_LOAD: begin
            q_cmd = CMD_LOAD;
            keep  = load_ok;
         end
         ACT_NEXT: begin
            q_cmd = CMD_NEXT;
            keep  = 1'b1;
         end
         ACT_RESTART: begin
            q_cmd = CMD_RESTART;
            keep  = 1'b1;
         end
         default: keep = 1'b0;
      endcase
   end

   // table slot and direction word aligned to the top of the fraction
   assign q_addr = AW'(int'(req_load_dimension) * BITS + int'(req_load_bit));
   assign q_word = load_ok ?
                   (WORD'(req_direction_value) << (WORD - 1 - int'(req_load_bit))) : '0;

   always_comb begin
      dims_in   = dims_ff;
      points_in = points_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DIMS_IN_USE:   dims_in   = csr_wdata[3:0];
            CSR_POINTS_IN_USE: points_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff   <= DIMS_RESET;
         points_ff <= POINTS_RESET;
      end else begin
         dims_ff   <= dims_in;
         points_ff <= points_in;
      end
   end

   // zero dims behaves as one, oversize is clamped
   always_comb begin
      if (dims_ff == '0) begin
         last_dim = '0;
      end else if (int'(dims_ff) > MAX_DIMS) begin
         last_dim = DW'(MAX_DIMS - 1);
      end else begin
         last_dim = DW'(dims_ff - 4'd1);
      end
      limit = (32'(points_ff) > CAP) ? 16'(CAP) : points_ff;
   end

endmodule

`default_nettype wire

FILE: hw/rtl/sobol_back.sv
// ---------------------------------------------------------------------------
// sobol_back
// executes queued commands: direction table, coordinate update, emission
// ---------------------------------------------------------------------------
`default_nettype none

module sobol_back #(
   parameter int BITS     = sobol_pkg::BITS_DEFAULT,
   parameter int MAX_DIMS = sobol_pkg::MAX_DIMS_DEFAULT,
   parameter int WORD     = sobol_pkg::WORD_DEFAULT,
   localparam int AW = (MAX_DIMS * BITS > 1) ? $clog2(MAX_DIMS * BITS) : 1,
   localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     q_valid,
   output logic                          q_pop,
   input  wire sobol_pkg::sobol_cmd_type q_cmd,
   input  wire logic [AW-1:0]            q_addr,
   input  wire logic [WORD-1:0]          q_word,
   input  wire logic [DW-1:0]            last_dim,
   input  wire logic [15:0]              limit,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [2:0]                    rsp_dimension,
   output logic [31:0]                   rsp_coordinate,
   output logic [14:0]                   rsp_point_index,
   output logic                          rsp_exhausted,
   output logic                          rsp_last,
   output sobol_pkg::sobol_status_type   status
);
   import sobol_pkg::*;

   localparam int DEPTH = MAX_DIMS * BITS;

   // direction table, a slot never loaded reads as zero
   logic [WORD-1:0]  dir_mem [DEPTH];
   logic [DEPTH-1:0] dir_vld_ff, dir_vld_in;
   logic [WORD-1:0]  rd_data_ff;
   logic             rd_en_ff, rd_en_in;

   logic [WORD-1:0]  coord_ff [MAX_DIMS];
   logic [WORD-1:0]  coord_in [MAX_DIMS];
   logic [15:0]      pdone_ff, pdone_in;

   sobol_state_type  state_ff, state_in;
   logic [DW-1:0]    dim_ff, dim_in;
   logic [DW-1:0]    last_ff, last_in;
   logic [AW-1:0]    base_ff, base_in;
   logic [14:0]      pidx_ff, pidx_in;
   logic             exh_ff, exh_in;
   logic             upd_ff, upd_in;

   logic             s2_vld_ff, s2_vld_in;
   logic [DW-1:0]    s2_dim_ff, s2_dim_in;
   logic             s2_emit_ff, s2_emit_in;
   logic             s2_last_ff, s2_last_in;
   logic [14:0]      s2_pidx_ff, s2_pidx_in;
   logic             s2_exh_ff, s2_exh_in;

   logic             rsp_vld_ff, rsp_vld_in;
   logic [2:0]       rsp_dim_ff, rsp_dim_in;
   logic [31:0]      rsp_coord_ff, rsp_coord_in;
   logic [14:0]      rsp_pidx_ff, rsp_pidx_in;
   logic             rsp_exh_ff, rsp_exh_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             out_free, s2_go, issue;
   logic [15:0]      pm1;
   logic [4:0]       tones;
   logic             exh_now, upd_now;
   logic [WORD-1:0]  coord_new;

   assign out_free  = !rsp_vld_ff || !rsp_stall;
   assign s2_go     = s2_vld_ff && (!s2_emit_ff || out_free);
   assign issue     = (state_ff == ST_RUN) && (!s2_vld_ff || s2_go);
   // a restart must not clear a coordinate still in flight
   assign q_pop     = (state_ff == ST_IDLE) && q_valid &&
                      ((q_cmd != CMD_RESTART) || !s2_vld_ff);
   assign coord_new = coord_ff[s2_dim_ff] ^ (rd_en_ff ? rd_data_ff : '0);

   // trailing ones of the previous point index
   always_comb begin
      logic stop;
      stop  = 1'b0;
      tones = '0;
      pm1   = pdone_ff - 16'd1;
      for (int i = 0; i < 16; i++) begin
         if (!stop && pm1[i]) begin
            tones = tones + 5'd1;
         end else begin
            stop = 1'b1;
         end
      end
      exh_now = (pdone_ff >= limit);
      upd_now = !exh_now && (pdone_ff != '0) && (int'(tones) < BITS);
   end

   always_comb begin
      dir_vld_in = dir_vld_ff;
      coord_in   = coord_ff;
      pdone_in   = pdone_ff;
      state_in   = state_ff;
      dim_in     = dim_ff;
      last_in    = last_ff;
      base_in    = base_ff;
      pidx_in    = pidx_ff;
      exh_in     = exh_ff;
      upd_in     = upd_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               case (q_cmd)
                  CMD_LOAD: dir_vld_in[q_addr] = 1'b1;
                  CMD_RESTART: begin
                     for (int d = 0; d < MAX_DIMS; d++) begin
                        coord_in[d] = '0;
                     end
                     pdone_in = '0;
                  end
                  CMD_NEXT: begin
                     exh_in  = exh_now;
                     upd_in  = upd_now;
                     base_in = upd_now ? AW'(tones) : '0;
                     dim_in  = '0;
                     last_in = last_dim;
                     if (exh_now) begin
                        pidx_in = (pdone_ff == '0) ? '0 : 15'(pdone_ff - 16'd1);
                     end else begin
                        pidx_in  = 15'(pdone_ff);
                        pdone_in = pdone_ff + 16'd1;
                     end
                     state_in = ST_RUN;
                  end
                  default: ;
               endcase
            end
         end
         ST_RUN: begin
            // every dimension advances, hidden ones too
            if (issue) begin
               dim_in  = dim_ff + 1'b1;
               base_in = base_ff + AW'(BITS);
               if (dim_ff == DW'(MAX_DIMS - 1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      s2_vld_in  = s2_vld_ff;
      s2_dim_in  = s2_dim_ff;
      s2_emit_in = s2_emit_ff;
      s2_last_in = s2_last_ff;
      s2_pidx_in = s2_pidx_ff;
      s2_exh_in  = s2_exh_ff;
      rd_en_in   = rd_en_ff;
      if (issue) begin
         s2_vld_in  = 1'b1;
         s2_dim_in  = dim_ff;
         s2_emit_in = (dim_ff <= last_ff);
         s2_last_in = (dim_ff == last_ff);
         s2_pidx_in = pidx_ff;
         s2_exh_in  = exh_ff;
         rd_en_in   = upd_ff && dir_vld_ff[base_ff];
      end else if (s2_go) begin
         s2_vld_in = 1'b0;
      end

      if (s2_go) begin
         coord_in[s2_dim_ff] = coord_new;
      end

      rsp_vld_in   = rsp_vld_ff;
      rsp_dim_in   = rsp_dim_ff;
      rsp_coord_in = rsp_coord_ff;
      rsp_pidx_in  = rsp_pidx_ff;
      rsp_exh_in   = rsp_exh_ff;
      rsp_last_in  = rsp_last_ff;
      if (s2_go && s2_emit_ff) begin
         rsp_vld_in   = 1'b1;
         rsp_dim_in   = 3'(s2_dim_ff);
         rsp_coord_in = 32'(coord_new);
         rsp_pidx_in  = s2_pidx_ff;
         rsp_exh_in   = s2_exh_ff;
         rsp_last_in  = s2_last_ff;
      end else if (!rsp_stall) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_vld_ff <= '0;
         for (int d = 0; d < MAX_DIMS; d++) begin
            coord_ff[d] <= '0;
         end
         pdone_ff  <= '0;
         state_ff  <= ST_IDLE;
         s2_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         dir_vld_ff <= dir_vld_in;
         coord_ff   <= coord_in;
         pdone_ff   <= pdone_in;
         state_ff   <= state_in;
         s2_vld_ff  <= s2_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      dim_ff       <= dim_in;
      last_ff      <= last_in;
      base_ff      <= base_in;
      pidx_ff      <= pidx_in;
      exh_ff       <= exh_in;
      upd_ff       <= upd_in;
      s2_dim_ff    <= s2_dim_in;
      s2_emit_ff   <= s2_emit_in;
      s2_last_ff   <= s2_last_in;
      s2_pidx_ff   <= s2_pidx_in;
      s2_exh_ff    <= s2_exh_in;
      rd_en_ff     <= rd_en_in;
      rsp_dim_ff   <= rsp_dim_in;
      rsp_coord_ff <= rsp_coord_in;
      rsp_pidx_ff  <= rsp_pidx_in;
      rsp_exh_ff   <= rsp_exh_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (q_pop && (q_cmd == CMD_LOAD)) begin
         dir_mem[q_addr] <= q_word;
      end
      if (issue) begin
         rd_data_ff <= dir_mem[base_ff];
      end
   end

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_dimension   = rsp_dim_ff;
   assign rsp_coordinate  = rsp_coord_ff;
   assign rsp_point_index = rsp_pidx_ff;
   assign rsp_exhausted   = rsp_exh_ff;
   assign rsp_last        = rsp_last_ff;

   assign status.running   = (state_ff == ST_RUN);
   assign status.stage_vld = s2_vld_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/sobol_sequence_generator_core.sv
// path: an accepted next transaction passes the queue, the run state, the table read
//   stage and the result register; a point steps through all MAX_DIMS dimensions with
//   one table read and one coordinate per cycle unless results stall
// reset: direction table valid bits, coordinates, point counter and queue clear at once,
//   csrs return to 8 dimensions and 32768 points; no clearing pass is needed
// ---------------------------------------------------------------------------
// sobol_sequence_generator_core
// gray-code sobol generator: decoding front end, command queue, execution back end
// ---------------------------------------------------------------------------
`default_nettype none

module sobol_sequence_generator_core #(
   parameter int BITS     = sobol_pkg::BITS_DEFAULT,
   parameter int MAX_DIMS = sobol_pkg::MAX_DIMS_DEFAULT,
   parameter int WORD     = sobol_pkg::WORD_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [2:0]  req_load_dimension,
   input  wire logic [3:0]  req_load_bit,
   input  wire logic [14:0] req_direction_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_dimension,
   output logic [31:0]      rsp_coordinate,
   output logic [14:0]      rsp_point_index,
   output logic             rsp_exhausted,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import sobol_pkg::*;

   `include "sobol_sequence_generator_core_assert.svh"

   localparam int AW = (MAX_DIMS * BITS > 1) ? $clog2(MAX_DIMS * BITS) : 1;
   localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int QW = 2 + AW + WORD;

   logic             f_push;
   sobol_cmd_type    f_cmd;
   logic [AW-1:0]    f_addr;
   logic [WORD-1:0]  f_word;
   logic [DW-1:0]    last_dim;
   logic [15:0]      limit;
   logic             q_ready;
   logic             q_valid;
   logic             q_pop;
   logic [QW-1:0]    q_data;
   sobol_cmd_type    q_cmd;
   sobol_status_type status;

   sobol_front #(
      .BITS     (BITS),
      .MAX_DIMS (MAX_DIMS),
      .WORD     (WORD)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_load_dimension  (req_load_dimension),
      .req_load_bit        (req_load_bit),
      .req_direction_value (req_direction_value),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .q_push              (f_push),
      .q_ready             (q_ready),
      .q_cmd               (f_cmd),
      .q_addr              (f_addr),
      .q_word              (f_word),
      .last_dim            (last_dim),
      .limit               (limit)
   );

   sobol_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data ({f_cmd, f_addr, f_word}),
      .ready     (q_ready),
      .valid     (q_valid),
      .pop       (q_pop),
      .pop_data  (q_data)
   );

   assign q_cmd = sobol_cmd_type'(q_data[QW-1 -: 2]);

   sobol_back #(
      .BITS     (BITS),
      .MAX_DIMS (MAX_DIMS),
      .WORD     (WORD)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_pop           (q_pop),
      .q_cmd           (q_cmd),
      .q_addr          (q_data[WORD +: AW]),
      .q_word          (q_data[WORD-1:0]),
      .last_dim        (last_dim),
      .limit           (limit),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_dimension   (rsp_dimension),
      .rsp_coordinate  (rsp_coordinate),
      .rsp_point_index (rsp_point_index),
      .rsp_exhausted   (rsp_exhausted),
      .rsp_last        (rsp_last),
      .status          (status)
   );

   `SOBOL_ASSERT_IMP(a_full_not_empty, !q_ready, q_valid, "queue full yet reports empty")
   `SOBOL_ASSERT_NXT(a_next_queued, req_valid && !req_stall && (req_action == ACT_NEXT), q_valid, "accepted next transaction not queued")
   `SOBOL_ASSERT_IMP(a_restart_drained, q_pop && (q_cmd == CMD_RESTART), !status.stage_vld, "restart taken with coordinate in flight")
   `SOBOL_ASSERT_IMP(a_pop_when_idle, q_pop, !status.running, "command taken while a point is running")

endmodule

`default_nettype wire

FILE: dv/tb.sv
// ---------------------------------------------------------------------------
// sobol sequence generator core bench
// drives load, next-point, restart and unused transactions with random gaps
// and result stalls, predicts every coordinate with an in-bench gray-code
// generator and compares each result field by field, over several settings
// of dimension count and point limit including a partly filled table run past its limit
// ---------------------------------------------------------------------------
module tb;
   import sobol_pkg::*;

   localparam int NUM_DIMS = MAX_DIMS_DEFAULT;
   localparam int NUM_BITS = BITS_DEFAULT;
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 24;
   localparam int CYCLE_LIMIT = 400_000;
   localparam int RANDOM_ITEMS = 240;
   localparam int SHORT_POINTS = 20;
   localparam int SHORT_BITS = 5;

   typedef enum int {GAPS_NONE, GAPS_FULL, GAPS_SPARSE} gap_style_type;

   typedef struct {
      logic [1:0]  action;
      logic [2:0]  load_dimension;
      logic [3:0]  load_bit;
      logic [14:0] direction_value;
   } sobol_req_type;

   typedef struct {
      logic [2:0]  dimension;
      logic [31:0] coordinate;
      logic [14:0] point_index;
      logic        exhausted;
      logic        last;
   } coord_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = '0;
   logic [2:0]  req_load_dimension = '0;
   logic [3:0]  req_load_bit = '0;
   logic [14:0] req_direction_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_dimension;
   logic [31:0] rsp_coordinate;
   logic [14:0] rsp_point_index;
   logic        rsp_exhausted;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   sobol_req_type  req_backlog[$];
   coord_rsp_type  coords_due[$];
   sobol_req_type  req_in_flight;
   bit             req_outstanding = 1'b0;

   // predicted generator state and register copies
   logic [31:0] dir_table [NUM_DIMS][NUM_BITS];
   logic [31:0] coord_now [NUM_DIMS];
   logic [15:0] points_done;
   logic [3:0]  dims_cfg;
   logic [15:0] points_cfg;

   gap_style_type  send_style = GAPS_SPARSE;
   gap_style_type  recv_style = GAPS_SPARSE;
   int          send_wait = 0;
   int          recv_wait = 0;
   int          error_count = 0;
   int          checked_count = 0;
   int          accepted_count = 0;
   int          cycle_count = 0;
   int          setting_count = 0;

   sobol_sequence_generator_core uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_load_dimension  (req_load_dimension),
      .req_load_bit        (req_load_bit),
      .req_direction_value (req_direction_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_dimension       (rsp_dimension),
      .rsp_coordinate      (rsp_coordinate),
      .rsp_point_index     (rsp_point_index),
      .rsp_exhausted       (rsp_exhausted),
      .rsp_last            (rsp_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function int draw_wait(input gap_style_type style);
      case (style)
         GAPS_NONE: return 0;
         GAPS_FULL: return $urandom_range(0, 17);
         default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
      endcase
   endfunction

   // advances the predicted generator by one transaction and queues its coordinates
   function void advance_sobol(input sobol_req_type it);
      int unsigned n_dims;
      int unsigned limit;
      int unsigned t;
      int          d;
      logic [15:0] prev;
      logic [14:0] pidx;
      logic        exh;
      coord_rsp_type  r;
      case (it.action)
         ACT_LOAD: begin
            if (it.load_bit < NUM_BITS)
               dir_table[it.load_dimension][it.load_bit] =
                  32'(it.direction_value) << (31 - it.load_bit);
         end
         ACT_RESTART: begin
            for (d = 0; d < NUM_DIMS; d++) coord_now[d] = '0;
            points_done = '0;
         end
         ACT_NEXT: begin
            n_dims = (dims_cfg == 0) ? 1 : (dims_cfg > NUM_DIMS) ? NUM_DIMS : dims_cfg;
            limit = (points_cfg < (1 << NUM_BITS)) ? points_cfg : (1 << NUM_BITS);
            exh = (points_done >= limit);
            if (exh) begin
               pidx = (points_done == 0) ? '0 : points_done[14:0] - 15'd1;
            end else begin
               pidx = points_done[14:0];
               if (points_done != 0) begin
                  // gray-code step: direction picked by trailing ones of the previous index
                  prev = points_done - 16'd1;
                  t = 0;
                  while (t < 16 && prev[t]) t++;
                  if (t < NUM_BITS)
                     for (d = 0; d < NUM_DIMS; d++) coord_now[d] ^= dir_table[d][t];
               end
               points_done = points_done + 16'd1;
            end
            for (d = 0; d < n_dims; d++) begin
               r.dimension   = d[2:0];
               r.coordinate  = coord_now[d];
               r.point_index = pidx;
               r.exhausted   = exh;
               r.last        = (d + 1 == n_dims);
               coords_due.insert(coords_due.size(), r);
            end
         end
         default: ;  // unused code leaves everything as it is
      endcase
   endfunction

   function void check_field(input string name, input logic [31:0] want_v, got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0h, got %0h", name, want_v, got_v);
         error_count++;
      end
   endfunction

   function void queue_item(input logic [1:0] action, input logic [2:0] dim,
                            input logic [3:0] bit_idx, input logic [14:0] value);
      sobol_req_type it;
      it.action          = action;
      it.load_dimension  = dim;
      it.load_bit        = bit_idx;
      it.direction_value = value;
      req_backlog.insert(req_backlog.size(), it);
   endfunction

   function void queue_op(input logic [1:0] action);
      queue_item(action, 3'($urandom), 4'($urandom), 15'($urandom));
   endfunction

   // odd and below 2^(bit+1)
   function logic [14:0] good_direction(input int unsigned bit_idx);
      return 15'(($urandom_range(0, (1 << bit_idx) - 1) << 1) | 1);
   endfunction

   // returns 1 when the transaction does something
   function int queue_random();
      int unsigned sel;
      int unsigned b;
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
         queue_op(ACT_NEXT);
         return 1;
      end else if (sel < 80) begin
         b = $urandom_range(0, NUM_BITS - 1);
         queue_item(ACT_LOAD, 3'($urandom_range(0, 7)), 4'(b), good_direction(b));
         return 1;
      end else if (sel < 88) begin
         queue_op(ACT_RESTART);
         return 1;
      end else if (sel < 94) begin
         // any bit index, any value: may be oversized or past the table
         b = $urandom_range(0, 15);
         queue_item(ACT_LOAD, 3'($urandom_range(0, 7)), 4'(b), 15'($urandom));
         return (b < NUM_BITS) ? 1 : 0;
      end else begin
         queue_op(ACT_UNUSED);
         return 0;
      end
   endfunction

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_DIMS_IN_USE:   dims_cfg = val[3:0];
         CSR_POINTS_IN_USE: points_cfg = val;
         default: ;
      endcase
   endtask

   // block idle: nothing left to send, nothing owed, and loads given time to land
   task automatic drain();
      while (req_backlog.size() != 0 || req_outstanding || coords_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      bit slot_free;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         slot_free = !req_valid;
         if (req_valid && !req_stall) begin
            advance_sobol(req_in_flight);
            accepted_count++;
            req_outstanding = 1'b0;
            slot_free = 1'b1;
         end
         if (slot_free) begin
            if (req_backlog.size() != 0 && send_wait == 0) begin
               req_in_flight = req_backlog.pop_front();
               req_outstanding = 1'b1;
               req_valid <= 1'b1;
               req_action <= req_in_flight.action;
               req_load_dimension <= req_in_flight.load_dimension;
               req_load_bit <= req_in_flight.load_bit;
               req_direction_value <= req_in_flight.direction_value;
               send_wait = draw_wait(send_style);
            end else begin
               req_valid <= 1'b0;
               if (send_wait > 0) send_wait--;
            end
         end
      end
   end

   // monitor and result stall
   always @(posedge clock) begin
      coord_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (coords_due.size() == 0) begin
               $error("unexpected transaction: dimension %0d coordinate %0h",
                      rsp_dimension, rsp_coordinate);
               error_count++;
            end else begin
               want = coords_due.pop_front();
               check_field("dimension", want.dimension, rsp_dimension);
               check_field("coordinate", want.coordinate, rsp_coordinate);
               check_field("point_index", want.point_index, rsp_point_index);
               check_field("exhausted", want.exhausted, rsp_exhausted);
               check_field("last", want.last, rsp_last);
               checked_count++;
            end
            recv_wait = draw_wait(recv_style);
         end
         if (recv_wait > 0) begin
            rsp_stall <= 1'b1;
            recv_wait--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timed out after %0d cycles, %0d coordinates still owed",
                  cycle_count, coords_due.size());
         $display("sobol_sequence_generator_core: mismatch");
         $finish;
      end
   end

   initial begin
      int random_sent;
      int n_items;
      int d;
      int b;
      random_sent = 0;
      for (d = 0; d < NUM_DIMS; d++) begin
         coord_now[d] = '0;
         for (b = 0; b < NUM_BITS; b++) dir_table[d][b] = '0;
      end
      points_done = '0;
      dims_cfg = DIMS_RESET;
      points_cfg = POINTS_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty table first, then edge loads
      queue_op(ACT_NEXT);
      queue_item(ACT_LOAD, 3'd0, 4'd0, 15'd1);
      queue_item(ACT_LOAD, 3'd7, 4'd14, 15'h7fff);
      queue_item(ACT_LOAD, 3'd3, 4'd1, 15'd3);
      queue_item(ACT_LOAD, 3'd5, 4'd13, 15'h2001);
      queue_item(ACT_LOAD, 3'd2, 4'd15, 15'd1);     // bit past the table
      queue_item(ACT_LOAD, 3'd1, 4'd0, 15'h7fff);   // upper bits fall off the word
      queue_item(ACT_LOAD, 3'd6, 4'd2, 15'd0);
      repeat (4) queue_op(ACT_NEXT);
      queue_item(ACT_UNUSED, 3'd7, 4'hf, 15'h7fff);
      queue_op(ACT_RESTART);
      queue_op(ACT_NEXT);
      drain();
      setting_count++;

      // zero dimensions read as one, single point then exhausted
      write_csr(CSR_DIMS_IN_USE, 16'd0);
      write_csr(CSR_POINTS_IN_USE, 16'd1);
      queue_op(ACT_RESTART);
      repeat (2) queue_op(ACT_NEXT);
      drain();
      setting_count++;

      // too many dimensions, zero point limit
      write_csr(CSR_DIMS_IN_USE, 16'd15);
      write_csr(CSR_POINTS_IN_USE, 16'd0);
      queue_op(ACT_RESTART);
      repeat (2) queue_op(ACT_NEXT);
      drain();
      setting_count++;

      // low table bits filled, run past a short point limit, full back-to-back
      send_style = GAPS_NONE;
      recv_style = GAPS_NONE;
      write_csr(CSR_DIMS_IN_USE, 16'd8);
      write_csr(CSR_POINTS_IN_USE, 16'(SHORT_POINTS));
      for (d = 0; d < NUM_DIMS; d++)
         for (b = 0; b < SHORT_BITS; b++)
            queue_item(ACT_LOAD, 3'(d), 4'(b), good_direction(b));
      queue_op(ACT_RESTART);
      repeat (SHORT_POINTS + 2) queue_op(ACT_NEXT);
      drain();
      setting_count++;

      while (random_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0:       write_csr(CSR_DIMS_IN_USE, 16'd0);
            1:       write_csr(CSR_DIMS_IN_USE, 16'd15);
            2:       write_csr(CSR_DIMS_IN_USE, 16'd8);
            3:       write_csr(CSR_DIMS_IN_USE, 16'd1);
            default: write_csr(CSR_DIMS_IN_USE, 16'($urandom_range(0, 15)));
         endcase
         case ($urandom_range(0, 6))
            0:       write_csr(CSR_POINTS_IN_USE, 16'd0);
            1:       write_csr(CSR_POINTS_IN_USE, 16'd1);
            2:       write_csr(CSR_POINTS_IN_USE, 16'hffff);
            3:       write_csr(CSR_POINTS_IN_USE, 16'd32768);
            6:       write_csr(CSR_POINTS_IN_USE, 16'($urandom));
            default: write_csr(CSR_POINTS_IN_USE, 16'($urandom_range(2, 40)));
         endcase
         send_style = gap_style_type'($urandom_range(0, 2));
         recv_style = gap_style_type'($urandom_range(0, 2));
         if ($urandom_range(0, 2) != 0) queue_op(ACT_RESTART);
         n_items = $urandom_range(20, 40);
         repeat (n_items) random_sent += queue_random();
         drain();
         setting_count++;
      end

      $display("covered %0d input transactions and %0d coordinates over %0d settings,",
               accepted_count, checked_count, setting_count);
      $display("including a filled table run past its point limit and a zero limit");
      if (error_count == 0) begin
         $display("sobol_sequence_generator_core: match");
      end else begin
         $display("sobol_sequence_generator_core: mismatch");
      end
      $finish;
   end

endmodule
